// ===== rtl/cau_pkg.sv =====
// Shared types, constants and clip helpers for the complex arithmetic unit.
package cau_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned ProdW = 64;
  localparam int unsigned SumW  = 65;
  localparam int unsigned QuoW  = 34;
  localparam int unsigned DivSteps = QuoW;
  // Divider stages: magnitude stage, overflow check stage, one stage per quotient bit
  localparam int unsigned DivLat = DivSteps + 2;

  localparam logic [1:0] OpAdd = 2'd0;
  localparam logic [1:0] OpSub = 2'd1;
  localparam logic [1:0] OpMul = 2'd2;
  localparam logic [1:0] OpDiv = 2'd3;

  typedef struct packed {
    logic [1:0]              action;
    logic signed [DataW-1:0] a_re;
    logic signed [DataW-1:0] a_im;
    logic signed [DataW-1:0] b_re;
    logic signed [DataW-1:0] b_im;
  } item_t;

  typedef struct packed {
    logic signed [DataW-1:0] res_re;
    logic signed [DataW-1:0] res_im;
    logic                    saturated;
    logic                    div_by_zero;
  } result_t;

  // Front end output: selected numerators, divisor and add/sub sums
  typedef struct packed {
    logic [1:0]             op;
    logic signed [SumW-1:0] sum_re;
    logic signed [SumW-1:0] sum_im;
    logic [ProdW-1:0]       den;
    logic signed [DataW:0]  as_re;
    logic signed [DataW:0]  as_im;
  } front_t;

  // One divider beat between bit stages
  typedef struct packed {
    logic [ProdW-1:0] rem;
    logic [QuoW-1:0]  num;
    logic [QuoW-1:0]  quo;
    logic [ProdW-1:0] den;
  } div_st_t;

  // Clip a signed 49-bit value to 32 bits; returns {sat, value}
  function automatic logic [DataW:0] clip49(input logic signed [48:0] v);
    logic [DataW:0] r;
    if (v > 49'sh0_7FFF_FFFF) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < -49'sh0_8000_0000) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[DataW-1:0]};
    end
    return r;
  endfunction

  // Clip a sign-magnitude quotient; returns {sat, value}
  function automatic logic [DataW:0] clip_quo(input logic neg, input logic ovf,
                                              input logic [QuoW-1:0] q);
    logic [DataW:0] r;
    if (neg) begin
      if (ovf || q > 34'h0_8000_0000) r = {1'b1, 32'h8000_0000};
      else r = {1'b0, 32'd0 - q[DataW-1:0]};
    end else begin
      if (ovf || q > 34'h0_7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
      else r = {1'b0, q[DataW-1:0]};
    end
    return r;
  endfunction

endpackage

// ===== rtl/cau_front.sv =====
// Front end: operand register, product stage and sum stage.
module cau_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  cau_pkg::item_t item_i,
  output logic           valid_o,
  output cau_pkg::front_t front_o
);
  import cau_pkg::*;

  item_t                   item_q;
  logic [1:0]              op_b_q;
  logic signed [ProdW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic [ProdW-1:0]        den_b_q;
  logic signed [DataW:0]   as_re_b_q, as_im_b_q;
  logic [2:0]              vld_q;
  front_t                  front_q, front_d;

  logic signed [DataW:0]   as_re_d, as_im_d;
  logic signed [ProdW-1:0] sq_r, sq_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_comb begin
    sq_r = item_q.b_re * item_q.b_re;
    sq_i = item_q.b_im * item_q.b_im;
    if (item_q.action == OpSub) begin
      as_re_d = {item_q.a_re[DataW-1], item_q.a_re} - {item_q.b_re[DataW-1], item_q.b_re};
      as_im_d = {item_q.a_im[DataW-1], item_q.a_im} - {item_q.b_im[DataW-1], item_q.b_im};
    end else begin
      as_re_d = {item_q.a_re[DataW-1], item_q.a_re} + {item_q.b_re[DataW-1], item_q.b_re};
      as_im_d = {item_q.a_im[DataW-1], item_q.a_im} + {item_q.b_im[DataW-1], item_q.b_im};
    end
  end

  always_comb begin
    front_d       = '0;
    front_d.op    = op_b_q;
    front_d.den   = den_b_q;
    front_d.as_re = as_re_b_q;
    front_d.as_im = as_im_b_q;
    if (op_b_q == OpDiv) begin
      front_d.sum_re = SumW'(p_rr_q) + SumW'(p_ii_q);
      front_d.sum_im = SumW'(p_ir_q) - SumW'(p_ri_q);
    end else begin
      front_d.sum_re = SumW'(p_rr_q) - SumW'(p_ii_q);
      front_d.sum_im = SumW'(p_ri_q) + SumW'(p_ir_q);
    end
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_i;
    op_b_q    <= item_q.action;
    p_rr_q    <= item_q.a_re * item_q.b_re;
    p_ii_q    <= item_q.a_im * item_q.b_im;
    p_ri_q    <= item_q.a_re * item_q.b_im;
    p_ir_q    <= item_q.a_im * item_q.b_re;
    den_b_q   <= $unsigned(sq_r) + $unsigned(sq_i);
    as_re_b_q <= as_re_d;
    as_im_b_q <= as_im_d;
    front_q   <= front_d;
  end

  assign valid_o = vld_q[2];
  assign front_o = front_q;

endmodule

// ===== rtl/cau_div_step.sv =====
// One restoring-division stage: one quotient bit per beat.
module cau_div_step (
  input  logic             clk_i,
  input  cau_pkg::div_st_t st_i,
  output cau_pkg::div_st_t st_o
);
  import cau_pkg::*;

  div_st_t          st_q, st_d;
  logic [ProdW-1:0] r2;
  logic             ge;

  always_comb begin
    r2       = {st_i.rem[ProdW-2:0], st_i.num[QuoW-1]};
    ge       = (r2 >= st_i.den);
    st_d.rem = ge ? r2 - st_i.den : r2;
    st_d.num = {st_i.num[QuoW-2:0], 1'b0};
    st_d.quo = {st_i.quo[QuoW-2:0], ge};
    st_d.den = st_i.den;
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  assign st_o = st_q;

endmodule

// ===== rtl/cau_div.sv =====
// Pipelined divider for one result part: (|n| << 16) / d with overflow check.
module cau_div (
  input  logic                             clk_i,
  input  logic signed [cau_pkg::SumW-1:0]  num_i,
  input  logic [cau_pkg::ProdW-1:0]        den_i,
  output logic                             neg_o,
  output logic                             ovf_o,
  output logic [cau_pkg::QuoW-1:0]         quo_o
);
  import cau_pkg::*;

  logic             neg_m_q;
  logic [ProdW-1:0] mag_q, den_m_q;
  logic [DivSteps:0] neg_q;
  logic [DivSteps:0] ovf_q;
  div_st_t          st [DivSteps+1];
  div_st_t          st_p_q, st_p_d;
  logic             ovf_d;

  always_comb begin
    // quotient reaches 2^34 exactly when |n| >= d << 18
    ovf_d      = ({18'd0, mag_q} >= {den_m_q, 18'd0});
    st_p_d.rem = {18'd0, mag_q[ProdW-1:18]};
    st_p_d.num = {mag_q[17:0], 16'd0};
    st_p_d.quo = '0;
    st_p_d.den = den_m_q;
  end

  always_ff @(posedge clk_i) begin
    neg_m_q <= num_i[SumW-1];
    mag_q   <= num_i[SumW-1] ? ProdW'(-num_i) : ProdW'(num_i);
    den_m_q <= den_i;
    st_p_q  <= st_p_d;
    neg_q   <= {neg_q[DivSteps-1:0], neg_m_q};
    ovf_q   <= {ovf_q[DivSteps-1:0], ovf_d};
  end

  assign st[0] = st_p_q;

  for (genvar i = 0; i < DivSteps; i++) begin : g_step
    cau_div_step u_step (
      .clk_i (clk_i),
      .st_i  (st[i]),
      .st_o  (st[i+1])
    );
  end

  assign neg_o = neg_q[DivSteps];
  assign ovf_o = ovf_q[DivSteps];
  assign quo_o = st[DivSteps].quo;

endmodule

// ===== rtl/complex_arithmetic_unit.sv =====
// Top level: complex add, subtract, multiply and divide on signed Q16.16 operands.
//
//   channel   ports                   beat taken when
//   --------  ----------------------  ------------------------
//   command   start, busy, item_i     start high, busy low
//   result    done_o, result_o        done_o high (one cycle)
//
// One item per cycle; the latency is the same for every operation.
// Latency is set by the divider: one quotient bit per stage, 34 stages.
// busy stays low; the pipeline never stalls and the receiver cannot stall.
// Reset clears only the valid bits; no item is in flight afterwards.
module complex_arithmetic_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  cau_pkg::item_t   item_i,
  output logic             done_o,
  output cau_pkg::result_t result_o
);
  import cau_pkg::*;

  typedef struct packed {
    logic [1:0] op;
    logic       dz;
    result_t    res;
  } side_t;

  logic             f_vld;
  front_t           f;
  side_t            side_d;
  side_t            side_q [DivLat];
  logic [DivLat-1:0] vld_q;
  logic             neg_re, ovf_re, neg_im, ovf_im;
  logic [QuoW-1:0]  quo_re, quo_im;
  logic [DataW:0]   c_re, c_im, q_re, q_im;
  result_t          result_d, result_q;
  logic             done_q;

  assign busy = 1'b0;

  cau_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start),
    .item_i  (item_i),
    .valid_o (f_vld),
    .front_o (f)
  );

  cau_div u_div_re (
    .clk_i (clk_i),
    .num_i (f.sum_re),
    .den_i (f.den),
    .neg_o (neg_re),
    .ovf_o (ovf_re),
    .quo_o (quo_re)
  );

  cau_div u_div_im (
    .clk_i (clk_i),
    .num_i (f.sum_im),
    .den_i (f.den),
    .neg_o (neg_im),
    .ovf_o (ovf_im),
    .quo_o (quo_im)
  );

  // add/sub and multiply finish here and ride alongside the divider
  always_comb begin
    if (f.op == OpMul) begin
      c_re = clip49(f.sum_re[SumW-1:16]);
      c_im = clip49(f.sum_im[SumW-1:16]);
    end else begin
      c_re = clip49(49'(f.as_re));
      c_im = clip49(49'(f.as_im));
    end
    side_d.op              = f.op;
    side_d.dz              = (f.den == '0);
    side_d.res.res_re      = c_re[DataW-1:0];
    side_d.res.res_im      = c_im[DataW-1:0];
    side_d.res.saturated   = c_re[DataW] | c_im[DataW];
    side_d.res.div_by_zero = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    for (int i = 1; i < DivLat; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[DivLat-2:0], f_vld};
      done_q <= vld_q[DivLat-1];
    end
  end

  always_comb begin
    q_re     = clip_quo(neg_re, ovf_re, quo_re);
    q_im     = clip_quo(neg_im, ovf_im, quo_im);
    result_d = side_q[DivLat-1].res;
    if (side_q[DivLat-1].op == OpDiv) begin
      if (side_q[DivLat-1].dz) begin
        result_d             = '0;
        result_d.div_by_zero = 1'b1;
      end else begin
        result_d.res_re      = q_re[DataW-1:0];
        result_d.res_im      = q_im[DataW-1:0];
        result_d.saturated   = q_re[DataW] | q_im[DataW];
        result_d.div_by_zero = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the complex arithmetic unit: directed table, then random beats.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cau_pkg::*;

  localparam int unsigned Latency  = 40;
  localparam int unsigned CycleCap = 100000;
  localparam int unsigned NumRand  = 1150;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    item_t   cmd;
    bit      typed;
    result_t res;
  } row_t;

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  logic    busy;
  item_t   item_i;
  logic    done_o;
  result_t result_o;

  result_t pending_res[$];
  int unsigned mismatches;
  int unsigned beats_in;
  int unsigned beats_out;
  int unsigned cycles;
  int unsigned n_divzero;
  int unsigned n_sat;
  row_t dir_rows[$];

  complex_arithmetic_unit uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .done_o  (done_o),
    .result_o(result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Clip to 32-bit signed; returns {clipped, value}
  function automatic logic [32:0] fit32(wide_t v);
    if (v > 128'sd2147483647) begin
      return {1'b1, 32'h7FFF_FFFF};
    end else if (v < -128'sd2147483648) begin
      return {1'b1, 32'h8000_0000};
    end
    return {1'b0, v[31:0]};
  endfunction

  // (n * 2^16) / d, truncated toward zero
  function automatic wide_t div_trunc(wide_t n, wide_t d);
    wide_t m;
    wide_t q;
    m = (n < 0) ? -n : n;
    q = (m <<< 16) / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic result_t complex_result(item_t it);
    wide_t ar, ai, br, bi, re, im, d;
    logic [32:0] cr, ci;
    result_t r;
    ar = $signed(it.a_re);
    ai = $signed(it.a_im);
    br = $signed(it.b_re);
    bi = $signed(it.b_im);
    r = '0;
    case (it.action)
      OpAdd: begin
        re = ar + br;
        im = ai + bi;
      end
      OpSub: begin
        re = ar - br;
        im = ai - bi;
      end
      OpMul: begin
        // arithmetic shift floors, i.e. rounds toward minus infinity
        re = (ar * br - ai * bi) >>> 16;
        im = (ar * bi + ai * br) >>> 16;
      end
      default: begin
        d = br * br + bi * bi;
        if (d == 0) begin
          r.div_by_zero = 1'b1;
          return r;
        end
        re = div_trunc(ar * br + ai * bi, d);
        im = div_trunc(ai * br - ar * bi, d);
      end
    endcase
    cr = fit32(re);
    ci = fit32(im);
    r.res_re    = cr[31:0];
    r.res_im    = ci[31:0];
    r.saturated = cr[32] | ci[32];
    return r;
  endfunction

  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5, 6: begin
        v = $urandom;
        v = {{12{v[19]}}, v[19:0]};
      end
      7: begin
        v = $urandom;
        v = {{16{v[15]}}, v[15:0]};
      end
      default: begin
        case ($urandom_range(0, 6))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'h0;
          3: v = 32'hFFFF_FFFF;
          4: v = 32'h1;
          5: v = 32'h0001_0000;
          default: v = 32'hFFFF_0000;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic item_t random_cmd();
    item_t it;
    it.action = 2'($urandom_range(0, 3));
    it.a_re = pick_operand();
    it.a_im = pick_operand();
    it.b_re = pick_operand();
    it.b_im = pick_operand();
    if (it.action == OpDiv && $urandom_range(0, 19) == 0) begin
      it.b_re = '0;
      it.b_im = '0;
    end
    return it;
  endfunction

  function automatic row_t mk_row(logic [1:0] op, logic [31:0] ar, logic [31:0] ai,
                                  logic [31:0] br, logic [31:0] bi, bit typed,
                                  logic [31:0] rr, logic [31:0] ri, logic s, logic z);
    row_t row;
    row.cmd   = '{action: op, a_re: ar, a_im: ai, b_re: br, b_im: bi};
    row.typed = typed;
    row.res   = '{res_re: rr, res_im: ri, saturated: s, div_by_zero: z};
    return row;
  endfunction

  // Result checker: each strobe is matched to the oldest outstanding beat
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      beats_out <= beats_out + 1;
      if (pending_res.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("unexpected result beat: %p", result_o);
      end else begin
        result_t want;
        want = pending_res.pop_front();
        if (result_o.res_re !== want.res_re || result_o.res_im !== want.res_im ||
            result_o.saturated !== want.saturated ||
            result_o.div_by_zero !== want.div_by_zero) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("mismatch: want re=%h im=%h sat=%b dz=%b got re=%h im=%h sat=%b dz=%b",
                     want.res_re, want.res_im, want.saturated, want.div_by_zero,
                     result_o.res_re, result_o.res_im, result_o.saturated,
                     result_o.div_by_zero);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleCap) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: done, errors");
      $finish;
    end
  end

  // Books a beat that the DUT has taken: queues its expected result and updates the counters
  task automatic note_accept(input result_t want);
    if (start && !busy) begin
      pending_res.push_back(want);
      beats_in = beats_in + 1;
      if (want.div_by_zero) n_divzero = n_divzero + 1;
      if (want.saturated) n_sat = n_sat + 1;
    end
  endtask

  // Presents one command and holds it until taken; idle_pct sets gap odds
  task automatic send_cmd(input item_t it, input result_t want, input int unsigned idle_pct);
    bit taken;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      if (start && !busy) begin
        note_accept(want);
        taken = 1'b1;
      end
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_res.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned idle_pct;
    item_t it;
    mismatches = 0;
    beats_in   = 0;
    beats_out  = 0;
    cycles     = 0;
    n_divzero  = 0;
    n_sat      = 0;
    rst_ni = 1'b0;
    start  = 1'b0;
    item_i = '0;

    dir_rows.push_back(mk_row(OpAdd, 0, 0, 0, 0, 1, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(OpAdd, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                              32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0));
    dir_rows.push_back(mk_row(OpAdd, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                              32'h8000_0000, 1, 32'h8000_0000, 32'h8000_0000, 1, 0));
    dir_rows.push_back(mk_row(OpSub, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                              32'h8000_0000, 1, 32'h8000_0000, 32'h7FFF_FFFF, 1, 0));
    dir_rows.push_back(mk_row(OpSub, 5, 7, 5, 7, 1, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(OpMul, 32'h0001_0000, 0, 32'h0001_0000, 0, 1,
                              32'h0001_0000, 0, 0, 0));
    dir_rows.push_back(mk_row(OpDiv, 32'h1234_5678, 32'h8000_0000, 0, 0, 1, 0, 0, 0, 1));
    dir_rows.push_back(mk_row(OpDiv, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 1, 0, 0, 0, 1));
    dir_rows.push_back(mk_row(OpDiv, 32'h0001_0000, 0, 32'h0001_0000, 0, 1,
                              32'h0001_0000, 0, 0, 0));
    dir_rows.push_back(mk_row(OpMul, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                              32'h8000_0000, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(OpMul, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                              32'h7FFF_FFFF, 0, 0, 0, 0, 0));
    // negative product below one lsb floors to minus one lsb
    dir_rows.push_back(mk_row(OpMul, 32'hFFFF_FFFF, 0, 1, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(OpDiv, 32'h8000_0000, 32'h8000_0000, 1, 0, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(OpDiv, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                              32'h8000_0000, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(OpDiv, 1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                              0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(OpDiv, 32'hFFFF_FFFF, 0, 0, 32'h0000_0003, 0, 0, 0, 0, 0));
    dir_rows.push_back(mk_row(OpSub, 0, 0, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_cmd(dir_rows[i].cmd,
               dir_rows[i].typed ? dir_rows[i].res : complex_result(dir_rows[i].cmd), 0);
    end
    // hold off until the pipeline is empty
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: idle_pct = 0;
        1: idle_pct = 62;
        2: idle_pct = 18;
        default: idle_pct = 0;
      endcase
      for (int n = 0; n < NumRand / 4; n++) begin
        it = random_cmd();
        send_cmd(it, complex_result(it), idle_pct);
      end
      if (ph == 1) drain();
    end

    drain();
    repeat (Latency + 10) @(posedge clk_i);

    $display("covered %0d beats in, %0d out: add, sub, mul, div, operand extremes,",
             beats_in, beats_out);
    $display("%0d zero divisors, %0d clipped results, gap phases 0/62/18 percent",
             n_divzero, n_sat);
    if (mismatches == 0 && pending_res.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("mismatches: %0d, left over: %0d", mismatches, pending_res.size());
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
